### rtl/core/pepl_pkg.sv
// Shared types and codes for the pin event ping-pong logger.
// Used by the controller, the datapath and the top level. No dependencies.
package pepl_pkg;

   // Operation codes carried in the kind field of a request.
   localparam logic [1:0] KIND_SET = 2'd0;
   localparam logic [1:0] KIND_CLR = 2'd1;
   localparam logic [1:0] KIND_INV = 2'd2;

   // One pin event on the request channel.
   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  pin;
      logic [31:0] stamp;
   } req_type;

   // One dumped entry on the response channel.
   typedef struct packed {
      logic [31:0] sample_word;
      logic [31:0] sample_time;
      logic        last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write;    // a request transfer completes this cycle
      logic load;     // capture the read data into the output register
      logic advance;  // the current entry was transferred, step the dump index
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic dump_needed;  // the offered request fills a bank while the other is full
      logic dump_last;    // the dump index points at the final entry of the bank
   } sts_type;

endpackage

### rtl/core/pin_event_pingpong_logger_unit.sv
// Pin event ping-pong logger: each request sets, clears or inverts one of 32
// pins and records the new pin word with its time stamp in a two-bank store.
//
// Request channel (req_valid, req_stall, req_payload): one pin event per
// transfer. An event of the unused kind is taken and has no effect.
// Response channel (rsp_valid, rsp_stall, rsp_payload): dumped entries, in
// store order, with last set on the final entry of a bank.
//
// A request that does not fill a bank is taken without a stall. When a
// request fills a bank while the other bank is full, that other bank is
// dumped as BANK_DEPTH responses; the first fill after reset dumps nothing.
// During a dump req_stall is high. Each response is read from the sample
// RAM, then held in the output register until the receiver drops
// rsp_stall, and the next request is taken only after the dump ends.
// A stalled response holds its payload.
//
// Reset clears the pin word, the fill count and the bank flags: bank 0 is
// active and the read bank is empty. The sample RAM itself is not cleared.
// Depends on pepl_pkg, pepl_ctrl, pepl_dpath and pepl_ram.
module pin_event_pingpong_logger_unit #(
   parameter int BANK_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pepl_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pepl_pkg::rsp_type rsp_payload
);
   import pepl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pepl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pepl_dpath #(
      .BANK_DEPTH (BANK_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

### rtl/core/pepl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pepl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, reading every cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pepl_ctrl.sv
// Controller state machine of the pin event ping-pong logger.
// Depends on pepl_pkg for the command and status structs.
module pepl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  pepl_pkg::sts_type sts,
   output pepl_pkg::cmd_type cmd
);
   import pepl_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   // Commands to the datapath.
   always_comb begin
      cmd.write   = req_xfer;
      cmd.load    = (state_ff == ST_LOAD);
      cmd.advance = rsp_xfer;
   end

   // Next state: a filling write that finds the other bank full starts a dump.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && sts.dump_needed) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_xfer) begin
               state_in = sts.dump_last ? ST_IDLE : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // A filling write that finds the other bank full always starts a dump.
   a_dump_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer && sts.dump_needed |=> state_ff == ST_LOAD)
      else $error("dump did not start after a filling write");

   // Every loaded entry is offered on the response channel next cycle.
   a_load_send: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> rsp_valid)
      else $error("loaded entry was not offered");

   // Between dumps the dump index rests at the first entry.
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !sts.dump_last)
      else $error("dump index not at the first entry while idle");
`endif

endmodule

### rtl/core/pepl_dpath.sv
// Datapath of the pin event ping-pong logger: pin word, bank bookkeeping,
// sample RAM and output register. Depends on pepl_pkg and pepl_ram.
module pepl_dpath #(
   parameter int BANK_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  pepl_pkg::req_type req_payload,
   output pepl_pkg::rsp_type rsp_payload,
   input  pepl_pkg::cmd_type cmd,
   output pepl_pkg::sts_type sts
);
   import pepl_pkg::*;

   localparam int IDX_W  = $clog2(BANK_DEPTH);
   localparam int ADDR_W = $clog2(2 * BANK_DEPTH);
   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(BANK_DEPTH - 1);
   localparam logic [ADDR_W-1:0] BANK_BASE = ADDR_W'(BANK_DEPTH);

   logic [31:0]       pin_word_ff, pin_word_in;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic              active_bank_ff, active_bank_in;
   logic              read_full_ff, read_full_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   rsp_type           out_ff;
   logic [31:0]       mask;
   logic              kind_ok;
   logic              fill_done;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [63:0]       rd_data;

   // Apply the pin operation; the unused kind leaves everything alone.
   assign mask = 32'd1 << req_payload.pin;
   always_comb begin
      kind_ok     = 1'b1;
      pin_word_in = pin_word_ff;
      case (req_payload.kind)
         KIND_SET: pin_word_in = pin_word_ff | mask;
         KIND_CLR: pin_word_in = pin_word_ff & ~mask;
         KIND_INV: pin_word_in = pin_word_ff ^ mask;
         default:  kind_ok     = 1'b0;
      endcase
      if (!cmd.write) begin
         pin_word_in = pin_word_ff;
      end
   end

   assign wr_en     = cmd.write && kind_ok;
   assign fill_done = kind_ok && (fill_ff == IDX_LAST);

   // Bank bookkeeping: a filled bank becomes the read bank and the banks swap.
   always_comb begin
      fill_in        = fill_ff;
      active_bank_in = active_bank_ff;
      read_full_in   = read_full_ff;
      if (wr_en) begin
         if (fill_done) begin
            fill_in        = '0;
            active_bank_in = !active_bank_ff;
            read_full_in   = 1'b1;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // Dump index steps on each transfer and wraps to the first entry at the end.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.advance) begin
         idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_word_ff    <= '0;
         fill_ff        <= '0;
         active_bank_ff <= 1'b0;
         read_full_ff   <= 1'b0;
         idx_ff         <= '0;
      end else begin
         pin_word_ff    <= pin_word_in;
         fill_ff        <= fill_in;
         active_bank_ff <= active_bank_in;
         read_full_ff   <= read_full_in;
         idx_ff         <= idx_in;
      end
   end

   // The bank being dumped is the active bank after the swap; it is addressed
   // with next-cycle values so the read data always matches the current index.
   assign wr_addr = (active_bank_ff ? BANK_BASE : '0) + ADDR_W'(fill_ff);
   assign rd_addr = (active_bank_in ? BANK_BASE : '0) + ADDR_W'(idx_in);

   pepl_ram #(
      .WIDTH (64),
      .DEPTH (2 * BANK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({pin_word_in, req_payload.stamp}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register holds the entry until it is transferred.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_ff.sample_word <= rd_data[63:32];
         out_ff.sample_time <= rd_data[31:0];
         out_ff.last        <= (idx_ff == IDX_LAST);
      end
   end

   assign rsp_payload = out_ff;

   always_comb begin
      sts.dump_needed = fill_done && read_full_ff;
      sts.dump_last   = (idx_ff == IDX_LAST);
   end

endmodule

### tb/tb_pin_event_pingpong_logger_unit.sv
// Self-checking testbench for pin_event_pingpong_logger_unit: random pin events with idle gaps
// and receiver stalls, checked against a ping-pong capture model kept in a scoreboard class.
// Depends on pepl_pkg and the pin_event_pingpong_logger_unit RTL.
module tb_pin_event_pingpong_logger_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pepl_pkg::*;

   localparam int BANK_DEPTH = 32;
   // The fourth kind code has no operation and is ignored by the block.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_EVENTS = 114;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Set during a stretch of the run in which neither side idles.
   bit steady = 1'b0;

   // Capture model: pin word, two-bank sample store and the dumps it should produce.
   class pin_capture_board;
      logic [31:0] pins = '0;
      logic [31:0] word_mem [2*BANK_DEPTH];
      logic [31:0] stamp_mem [2*BANK_DEPTH];
      int          fill = 0;
      bit          active = 1'b0;
      bit          read_side = 1'b1;
      bit          read_full = 1'b0;
      rsp_type     dump_queue [$];
      int          fault_count = 0;

      task report_fault(string msg);
         fault_count++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      // Applies one accepted pin event and queues any dumped entries it causes.
      function void note_event(req_type ev);
         logic [31:0] mask;
         int          base;
         rsp_type     entry;
         mask = 32'd1 << ev.pin;
         case (ev.kind)
            KIND_SET: pins = pins | mask;
            KIND_CLR: pins = pins & ~mask;
            KIND_INV: pins = pins ^ mask;
            default: return;
         endcase
         word_mem[int'(active) * BANK_DEPTH + fill] = pins;
         stamp_mem[int'(active) * BANK_DEPTH + fill] = ev.stamp;
         fill++;
         if (fill == BANK_DEPTH) begin
            // The bank that filled one period earlier is dumped first, if it is full.
            if (read_full) begin
               base = int'(read_side) * BANK_DEPTH;
               for (int i = 0; i < BANK_DEPTH; i++) begin
                  entry.sample_word = word_mem[base + i];
                  entry.sample_time = stamp_mem[base + i];
                  entry.last = (i == BANK_DEPTH - 1);
                  dump_queue.push_back(entry);
               end
            end
            read_side = active;
            read_full = 1'b1;
            active = ~active;
            fill = 0;
         end
      endfunction

      // Compares one response transfer with the oldest pending entry.
      task check_entry(rsp_type got);
         rsp_type want;
         bit      bad;
         if (dump_queue.size() == 0) begin
            report_fault($sformatf("response with nothing pending: word %h time %h last %b",
                                   got.sample_word, got.sample_time, got.last));
            return;
         end
         want = dump_queue.pop_front();
         bad = 1'b0;
         if (got.sample_word !== want.sample_word) bad = 1'b1;
         if (got.sample_time !== want.sample_time) bad = 1'b1;
         if (got.last !== want.last) bad = 1'b1;
         if (bad) begin
            report_fault($sformatf("got word %h time %h last %b, want word %h time %h last %b",
                                   got.sample_word, got.sample_time, got.last,
                                   want.sample_word, want.sample_time, want.last));
         end
      endtask
   endclass

   pin_capture_board board = new();

   pin_event_pingpong_logger_unit #(
      .BANK_DEPTH(BANK_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // Free-running 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver stalls at random except during the steady stretch.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 14);
   end

   // Every response transfer is checked as it completes.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_entry(rsp_payload);
      end
   end

   // Offers one event, with random idle cycles ahead of it, and waits for its transfer.
   task automatic send_event(input req_type ev);
      while (!steady && ($urandom_range(99) < 14)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_event(ev);
   endtask

   task automatic send_fields(input logic [1:0] kind, input logic [4:0] pin,
                              input logic [31:0] stamp);
      req_type ev;
      ev.kind = kind;
      ev.pin = pin;
      ev.stamp = stamp;
      send_event(ev);
   endtask

   // Main sequence: reset, directed events, random events, drain.
   initial begin
      req_type ev;
      int      counted;
      counted = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, every operation, the ignored kind,
      // redundant set and clear, and a double invert.
      send_fields(KIND_SET, 5'd0, 32'h0000_0000);
      send_fields(KIND_SET, 5'd31, 32'hFFFF_FFFF);
      send_fields(KIND_SET, 5'd31, 32'h0000_0001);
      send_fields(KIND_CLR, 5'd0, 32'h8000_0000);
      send_fields(KIND_CLR, 5'd0, 32'h7FFF_FFFF);
      send_fields(KIND_UNUSED, 5'd31, 32'hFFFF_FFFF);
      send_fields(KIND_INV, 5'd5, 32'h1234_5678);
      send_fields(KIND_INV, 5'd5, 32'h1234_5679);
      send_fields(KIND_INV, 5'd31, 32'hDEAD_BEEF);
      send_fields(KIND_UNUSED, 5'd0, 32'h0000_0000);
      send_fields(KIND_INV, 5'd16, 32'hFFFF_FFFE);
      send_fields(KIND_CLR, 5'd31, 32'hAAAA_AAAA);
      send_fields(KIND_SET, 5'd15, 32'h5555_5555);
      send_fields(KIND_CLR, 5'd16, 32'h0F0F_0F0F);
      send_fields(KIND_SET, 5'd1, 32'hF0F0_F0F0);
      send_fields(KIND_INV, 5'd0, 32'h0000_FFFF);

      // Random events; the ignored kind shows up now and then as noise.
      while (counted < RANDOM_EVENTS) begin
         steady = (counted >= 50) && (counted < 85);
         if ($urandom_range(99) < 6) begin
            ev.kind = KIND_UNUSED;
         end else begin
            ev.kind = 2'($urandom_range(2));
         end
         ev.pin = 5'($urandom_range(31));
         ev.stamp = $urandom;
         send_event(ev);
         if (ev.kind != KIND_UNUSED) counted++;
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // Drain the pending dumps, then allow for a late stray transfer.
      while (board.dump_queue.size() != 0) @(posedge clock);
      repeat (2 * BANK_DEPTH + 20) @(posedge clock);

      if (board.fault_count == 0 && board.dump_queue.size() == 0) begin
         $display("pin_event_pingpong_logger_unit verification clean");
      end else begin
         $display("pin_event_pingpong_logger_unit verification failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #500_000;
      $display("pin_event_pingpong_logger_unit verification failed");
      $finish;
   end

endmodule
